[src/id3cp_pkg.sv]
// shared types, configuration codes and default sizes of the id3v2 chapter parser
// used by id3cp_parser and id3v2_chapter_parser_core
package id3cp_pkg;

  localparam int MAX_TAG_BYTES_DEF     = 4194304;
  localparam int MAX_CHAPTER_COUNT_DEF = 1024;
  localparam int TITLE_CHARS_DEF       = 63;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORDS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_ONLY = 2'd1;
  localparam logic [10:0] MAX_RECORDS_RESET = 11'd1024;

  // one parser event: a finished chapter record and/or end of file
  typedef struct packed {
    logic        rec;
    logic        done;
    logic [9:0]  idx;
    logic [31:0] start;
    logic        bank;
    logic [10:0] count;
  } ev_t;

  function automatic logic [27:0] syncsafe(input logic [31:0] v);
    syncsafe = {v[30:24], v[22:16], v[14:8], v[6:0]};
  endfunction

endpackage

[src/id3v2_chapter_parser_core.sv]
// top level of the id3v2 chapter parser: config registers, event slot and record streamer
// depends on id3cp_pkg, id3cp_parser and id3cp_ram
//
// usage:
//   input channel (in_valid/in_ready) takes one file byte per beat, last_byte on the
//   final byte of a file. output channel (out_valid/out_ready) gives one beat per
//   title character of each chapter record, one beat with char_valid 0 for an empty
//   title, and the beat that closes the file carries stream_done and chapter_count.
//   config channel (cfg_valid/cfg_ready) is always ready; index 0 is max_records,
//   index 1 is presence_only, other indexes are dropped.
//   throughput: one input byte per cycle. a record streams one beat per cycle, while the
//   receiver is ready, from a two-bank title ram, so a record gives max(1, title length)
//   beats; in_ready drops only while a finished record or end of file waits behind one
//   still streaming. the first beat of a record reaches the outputs through the event
//   slot, streamer, ram read stage and output register, in that order.
//   when the receiver stalls, the output register holds and the ram read stage waits;
//   the parser keeps running until the event slot is full.
//   reset: parse state, config and all valids are set at once; there is no clearing pass.
module id3v2_chapter_parser_core #(
  parameter int MAX_TAG_BYTES     = id3cp_pkg::MAX_TAG_BYTES_DEF,
  parameter int MAX_CHAPTER_COUNT = id3cp_pkg::MAX_CHAPTER_COUNT_DEF,
  parameter int TITLE_CHARS       = id3cp_pkg::TITLE_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           record_valid,
  output logic [9:0]                     chapter_index,
  output logic [31:0]                    start_ms,
  output logic [7:0]                     title_char,
  output logic                           char_valid,
  output logic                           record_last,
  output logic                           stream_done,
  output logic [10:0]                    chapter_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [id3cp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [id3cp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import id3cp_pkg::*;

  localparam int LEN_W = $clog2(TITLE_CHARS + 1);

  typedef struct packed {
    logic        rec;
    logic [9:0]  idx;
    logic [31:0] start;
    logic        cv;
    logic        rlast;
    logic        done;
    logic [10:0] count;
  } beat_t;

  logic [10:0] max_records;
  logic        presence_only;

  logic             accept;
  logic             ev_valid;
  ev_t              ev;
  logic [LEN_W-1:0] ev_kept;
  logic             ram_we;
  logic [LEN_W:0]   ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  logic             job_valid;
  ev_t              job_ev;
  logic [LEN_W-1:0] job_kept;
  logic             job_take;

  logic             act_valid;
  ev_t              act_ev;
  logic [LEN_W-1:0] act_kept;
  logic [LEN_W-1:0] act_i;
  logic             entry_last;
  logic             issue;
  beat_t            issue_beat;

  logic  s1_valid;
  beat_t s1;
  logic  ram_en;
  logic  out_load;
  beat_t out_b;
  logic [7:0] out_char;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_records   <= MAX_RECORDS_RESET;
      presence_only <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_RECORDS:   max_records <= cfg_data;
        CFG_PRESENCE_ONLY: presence_only <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the event slot can refill in the cycle it hands its event to the streamer
  assign in_ready = !job_valid || job_take;
  assign accept   = in_valid && in_ready;

  id3cp_parser #(
    .MAX_TAG_BYTES     (MAX_TAG_BYTES),
    .MAX_CHAPTER_COUNT (MAX_CHAPTER_COUNT),
    .TITLE_CHARS       (TITLE_CHARS),
    .LEN_W             (LEN_W)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .max_records   (max_records),
    .presence_only (presence_only),
    .ev_valid      (ev_valid),
    .ev            (ev),
    .ev_kept       (ev_kept),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata)
  );

  id3cp_ram #(
    .WIDTH (8),
    .DEPTH (2 ** (LEN_W + 1))
  ) u_title_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_en),
    .raddr ({act_ev.bank, act_i}),
    .rdata (ram_rdata)
  );

  // streamer: one beat issued per cycle from the active event while the ram read stage can advance
  assign entry_last = !act_ev.rec || (act_kept == '0) ||
                      (({1'b0, act_i} + (LEN_W + 1)'(1)) == {1'b0, act_kept});
  assign out_load   = s1_valid && (!out_valid || out_ready);
  assign ram_en     = !s1_valid || out_load;
  assign issue      = act_valid && ram_en;
  assign job_take   = job_valid && (!act_valid || (issue && entry_last));

  always_comb begin
    issue_beat       = '0;
    issue_beat.rec   = act_ev.rec;
    issue_beat.idx   = act_ev.rec ? act_ev.idx : 10'd0;
    issue_beat.start = act_ev.rec ? act_ev.start : 32'd0;
    issue_beat.cv    = act_ev.rec && (act_kept != '0);
    issue_beat.rlast = act_ev.rec && entry_last;
    issue_beat.done  = act_ev.done && entry_last;
    issue_beat.count = (act_ev.done && entry_last) ? act_ev.count : 11'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (ev_valid) begin
      job_valid <= 1'b1;
    end else if (job_take) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid) begin
      job_ev   <= ev;
      job_kept <= ev_kept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
    end else if (job_take) begin
      act_valid <= 1'b1;
    end else if (issue && entry_last) begin
      act_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      act_ev   <= job_ev;
      act_kept <= job_kept;
      act_i    <= '0;
    end else if (issue) begin
      act_i <= act_i + LEN_W'(1);
    end
  end

  // ram read stage, moves in step with the ram read enable
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ram_en) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_en) begin
      s1 <= issue_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_b    <= s1;
      out_char <= s1.cv ? ram_rdata : 8'd0;
    end
  end

  assign record_valid  = out_b.rec;
  assign chapter_index = out_b.idx;
  assign start_ms      = out_b.start;
  assign title_char    = out_char;
  assign char_valid    = out_b.cv;
  assign record_last   = out_b.rlast;
  assign stream_done   = out_b.done;
  assign chapter_count = out_b.count;

  // a pending event is picked up as soon as the streamer is free
  a_job_taken: assert property (@(posedge clk) disable iff (rst)
    job_valid && !act_valid |=> act_valid)
    else $error("pending event not taken by idle streamer");

  // the parser never writes the bank that is being streamed
  a_bank_apart: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && act_valid && act_ev.rec && (ram_waddr[LEN_W] == act_ev.bank)))
    else $error("title write into bank being streamed");

  // every end of file produces a closing event
  a_last_event: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte |=> job_valid)
    else $error("end of file left no event");

endmodule

[src/id3cp_ram.sv]
// generic single write port, single read port ram with registered read and read enable
// no dependencies
module id3cp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/id3cp_parser.sv]
// byte-wise id3v2 header, frame and chap/tit2 parser; writes title bytes to a banked ram
// depends on id3cp_pkg
module id3cp_parser #(
  parameter int MAX_TAG_BYTES     = id3cp_pkg::MAX_TAG_BYTES_DEF,
  parameter int MAX_CHAPTER_COUNT = id3cp_pkg::MAX_CHAPTER_COUNT_DEF,
  parameter int TITLE_CHARS       = id3cp_pkg::TITLE_CHARS_DEF,
  parameter int LEN_W             = $clog2(TITLE_CHARS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic [10:0]       max_records,
  input  logic              presence_only,
  output logic              ev_valid,
  output id3cp_pkg::ev_t    ev,
  output logic [LEN_W-1:0]  ev_kept,
  output logic              ram_we,
  output logic [LEN_W:0]    ram_waddr,
  output logic [7:0]        ram_wdata
);
  import id3cp_pkg::*;

  localparam int TAG_W = $clog2(MAX_TAG_BYTES + 1);

  localparam logic [2:0] PH_HDR     = 3'd0;
  localparam logic [2:0] PH_EXT     = 3'd1;
  localparam logic [2:0] PH_EXTSKIP = 3'd2;
  localparam logic [2:0] PH_FHDR    = 3'd3;
  localparam logic [2:0] PH_BODY    = 3'd4;
  localparam logic [2:0] PH_STOP    = 3'd5;

  localparam logic [3:0] C_ID     = 4'd0;
  localparam logic [3:0] C_TIMES  = 4'd1;
  localparam logic [3:0] C_SUBHDR = 4'd2;
  localparam logic [3:0] C_SKIP   = 4'd3;
  localparam logic [3:0] C_ENC    = 4'd4;
  localparam logic [3:0] C_BOM    = 4'd5;
  localparam logic [3:0] C_PAIR   = 4'd6;
  localparam logic [3:0] C_TEXT   = 4'd7;
  localparam logic [3:0] C_DONE   = 4'd8;

  localparam logic [31:0] ID_CHAP = 32'h43484150;
  localparam logic [31:0] ID_TIT2 = 32'h54495432;

  logic [2:0]       phase, phase_next;
  logic [TAG_W-1:0] tag_pos, tag_pos_next, tag_len, tag_len_next;
  logic [31:0]      hdr_bytes, hdr_bytes_next;
  logic             v4, v4_next, ext_flag, ext_flag_next;
  logic [31:0]      frame_ident, frame_ident_next, frame_rem, frame_rem_next;
  logic [3:0]       hdr_count, hdr_count_next;
  logic [3:0]       chap_phase, chap_phase_next;
  logic [4:0]       chap_off, chap_off_next;
  logic [31:0]      start_time, start_time_next;
  logic [31:0]      sub_ident, sub_ident_next, sub_rem, sub_rem_next;
  logic             little, little_next;
  logic [7:0]       pair_first, pair_first_next;
  logic [LEN_W-1:0] title_len, title_len_next, kept_len, kept_len_next;
  logic [10:0]      found, found_next;
  logic             wbank;

  logic [27:0] hsize;
  logic [31:0] ext_len, fsize, ssize;
  logic [7:0]  first_b, app_char, lo, hi;
  logic        do_app, is_rec;

  function automatic logic bf_fail(input logic [TAG_W-1:0] tp, input logic [TAG_W-1:0] tl,
                                   input logic [10:0] fc);
    bf_fail = (({1'b0, tp} + (TAG_W + 1)'(10)) > {1'b0, tl}) ||
              (fc >= 11'(MAX_CHAPTER_COUNT));
  endfunction

  always_comb begin
    phase_next       = phase;
    tag_pos_next     = tag_pos;
    tag_len_next     = tag_len;
    hdr_bytes_next   = hdr_bytes;
    v4_next          = v4;
    ext_flag_next    = ext_flag;
    frame_ident_next = frame_ident;
    frame_rem_next   = frame_rem;
    hdr_count_next   = hdr_count;
    chap_phase_next  = chap_phase;
    chap_off_next    = chap_off;
    start_time_next  = start_time;
    sub_ident_next   = sub_ident;
    sub_rem_next     = sub_rem;
    little_next      = little;
    pair_first_next  = pair_first;
    title_len_next   = title_len;
    kept_len_next    = kept_len;
    found_next       = found;
    hsize    = '0;
    ext_len  = '0;
    fsize    = '0;
    ssize    = '0;
    first_b  = '0;
    app_char = '0;
    lo       = '0;
    hi       = '0;
    do_app   = 1'b0;
    is_rec   = 1'b0;
    ev       = '0;
    ram_we   = 1'b0;
    ram_wdata = '0;
    ram_waddr = {wbank, title_len};

    if (accept) begin
      case (phase)
        PH_HDR: begin
          if ((tag_pos == TAG_W'(0) && data_byte != 8'h49) ||
              (tag_pos == TAG_W'(1) && data_byte != 8'h44) ||
              (tag_pos == TAG_W'(2) && data_byte != 8'h33)) begin
            phase_next = PH_STOP;
          end else begin
            if (tag_pos == TAG_W'(3)) v4_next = (data_byte >= 8'd4);
            if (tag_pos == TAG_W'(5)) ext_flag_next = data_byte[6];
            if (tag_pos >= TAG_W'(6)) hdr_bytes_next = {hdr_bytes[23:0], data_byte};
            if (tag_pos < TAG_W'(9)) begin
              tag_pos_next = tag_pos + TAG_W'(1);
            end else begin
              hsize = syncsafe(hdr_bytes_next);
              tag_pos_next = '0;
              hdr_bytes_next = '0;
              if (hsize == 28'd0 || hsize > 28'(MAX_TAG_BYTES)) begin
                phase_next = PH_STOP;
              end else begin
                tag_len_next = hsize[TAG_W-1:0];
                if (ext_flag_next) begin
                  phase_next = (hsize < 28'd4) ? PH_STOP : PH_EXT;
                end else if (bf_fail('0, tag_len_next, found)) begin
                  phase_next = PH_STOP;
                end else begin
                  phase_next = PH_FHDR;
                  hdr_count_next = '0;
                  frame_ident_next = '0;
                  frame_rem_next = '0;
                end
              end
            end
          end
        end
        PH_EXT: begin
          tag_pos_next = tag_pos + TAG_W'(1);
          hdr_bytes_next = {hdr_bytes[23:0], data_byte};
          if (tag_pos_next >= TAG_W'(4)) begin
            ext_len = v4 ? {4'd0, syncsafe(hdr_bytes_next)} : hdr_bytes_next + 32'd4;
            if (ext_len >= {{(32-TAG_W){1'b0}}, tag_len}) begin
              phase_next = PH_STOP;
            end else if (ext_len > 32'd4) begin
              frame_rem_next = ext_len;
              phase_next = PH_EXTSKIP;
            end else begin
              tag_pos_next = ext_len[TAG_W-1:0];
              if (bf_fail(ext_len[TAG_W-1:0], tag_len, found)) begin
                phase_next = PH_STOP;
              end else begin
                phase_next = PH_FHDR;
                hdr_count_next = '0;
                frame_ident_next = '0;
                frame_rem_next = '0;
                // short extended header: its length bytes are reread as frame id bytes
                if (ext_len < 32'd4) begin
                  case (ext_len[1:0])
                    2'd0: begin
                      first_b = hdr_bytes_next[31:24];
                      frame_ident_next = hdr_bytes_next;
                    end
                    2'd1: begin
                      first_b = hdr_bytes_next[23:16];
                      frame_ident_next = {8'd0, hdr_bytes_next[23:0]};
                    end
                    2'd2: begin
                      first_b = hdr_bytes_next[15:8];
                      frame_ident_next = {16'd0, hdr_bytes_next[15:0]};
                    end
                    default: begin
                      first_b = hdr_bytes_next[7:0];
                      frame_ident_next = {24'd0, hdr_bytes_next[7:0]};
                    end
                  endcase
                  if (first_b == 8'd0) begin
                    phase_next = PH_STOP;
                  end else begin
                    hdr_count_next = 4'd4 - {2'd0, ext_len[1:0]};
                    tag_pos_next = TAG_W'(4);
                  end
                end
              end
            end
          end
        end
        PH_EXTSKIP: begin
          tag_pos_next = tag_pos + TAG_W'(1);
          if ({{(32-TAG_W){1'b0}}, tag_pos_next} >= frame_rem) begin
            if (bf_fail(tag_pos_next, tag_len, found)) begin
              phase_next = PH_STOP;
            end else begin
              phase_next = PH_FHDR;
              hdr_count_next = '0;
              frame_ident_next = '0;
              frame_rem_next = '0;
            end
          end
        end
        PH_FHDR: begin
          tag_pos_next = tag_pos + TAG_W'(1);
          if (hdr_count == 4'd0 && data_byte == 8'd0) begin
            phase_next = PH_STOP;
          end else begin
            if (hdr_count < 4'd4) frame_ident_next = {frame_ident[23:0], data_byte};
            else if (hdr_count < 4'd8) frame_rem_next = {frame_rem[23:0], data_byte};
            hdr_count_next = hdr_count + 4'd1;
            if (hdr_count_next == 4'd10) begin
              fsize = v4 ? {4'd0, syncsafe(frame_rem_next)} : frame_rem_next;
              if (fsize == 32'd0 ||
                  ({1'b0, fsize} + {{(33-TAG_W){1'b0}}, tag_pos_next}) >
                  {{(33-TAG_W){1'b0}}, tag_len}) begin
                phase_next = PH_STOP;
              end else begin
                frame_rem_next = fsize;
                phase_next = PH_BODY;
                chap_phase_next = C_ID;
                chap_off_next = '0;
                start_time_next = '0;
                title_len_next = '0;
                kept_len_next = '0;
              end
            end
          end
        end
        PH_BODY: begin
          tag_pos_next = tag_pos + TAG_W'(1);
          frame_rem_next = frame_rem - 32'd1;
          if (frame_ident == ID_CHAP) begin
            case (chap_phase)
              C_ID: begin
                if (data_byte == 8'd0) begin
                  chap_phase_next = C_TIMES;
                  chap_off_next = '0;
                end
              end
              C_TIMES: begin
                if (chap_off < 5'd4) start_time_next = {start_time[23:0], data_byte};
                chap_off_next = chap_off + 5'd1;
                if (chap_off_next == 5'd16) begin
                  hdr_count_next = '0;
                  sub_ident_next = '0;
                  sub_rem_next = '0;
                  chap_phase_next = (frame_rem_next < 32'd10) ? C_DONE : C_SUBHDR;
                end
              end
              C_SUBHDR: begin
                if (hdr_count < 4'd4) sub_ident_next = {sub_ident[23:0], data_byte};
                else if (hdr_count < 4'd8) sub_rem_next = {sub_rem[23:0], data_byte};
                hdr_count_next = hdr_count + 4'd1;
                if (hdr_count_next == 4'd10) begin
                  ssize = v4 ? {4'd0, syncsafe(sub_rem_next)} : sub_rem_next;
                  if (ssize == 32'd0 || ssize > frame_rem_next) begin
                    chap_phase_next = C_DONE;
                  end else begin
                    sub_rem_next = ssize;
                    chap_phase_next = (sub_ident_next == ID_TIT2) ? C_ENC : C_SKIP;
                  end
                end
              end
              C_SKIP: begin
                sub_rem_next = sub_rem - 32'd1;
                if (sub_rem_next == 32'd0) begin
                  hdr_count_next = '0;
                  sub_ident_next = '0;
                  sub_rem_next = '0;
                  chap_phase_next = (frame_rem_next < 32'd10) ? C_DONE : C_SUBHDR;
                end
              end
              C_ENC: begin
                sub_rem_next = sub_rem - 32'd1;
                chap_off_next = '0;
                little_next = 1'b0;
                if (data_byte == 8'd1) chap_phase_next = C_BOM;
                else if (data_byte == 8'd2) chap_phase_next = C_PAIR;
                else chap_phase_next = C_TEXT;
                if (sub_rem_next == 32'd0) chap_phase_next = C_DONE;
              end
              C_BOM: begin
                sub_rem_next = sub_rem - 32'd1;
                if (chap_off == 5'd0) begin
                  pair_first_next = data_byte;
                  chap_off_next = 5'd1;
                end else begin
                  little_next = (pair_first == 8'hFF) && (data_byte == 8'hFE);
                  chap_off_next = '0;
                  chap_phase_next = C_PAIR;
                end
                if (sub_rem_next == 32'd0) chap_phase_next = C_DONE;
              end
              C_PAIR: begin
                sub_rem_next = sub_rem - 32'd1;
                if (chap_off == 5'd0) begin
                  pair_first_next = data_byte;
                  chap_off_next = 5'd1;
                end else begin
                  lo = little ? pair_first : data_byte;
                  hi = little ? data_byte : pair_first;
                  chap_off_next = '0;
                  if (lo == 8'd0 && hi == 8'd0) begin
                    chap_phase_next = C_DONE;
                  end else begin
                    do_app = 1'b1;
                    app_char = (hi != 8'd0) ? 8'h3F : lo;
                  end
                end
                if (sub_rem_next == 32'd0) chap_phase_next = C_DONE;
              end
              C_TEXT: begin
                sub_rem_next = sub_rem - 32'd1;
                if (data_byte == 8'd0) begin
                  chap_phase_next = C_DONE;
                end else begin
                  do_app = 1'b1;
                  app_char = data_byte;
                end
                if (sub_rem_next == 32'd0) chap_phase_next = C_DONE;
              end
              default: ;
            endcase
            if (do_app) begin
              if (title_len < LEN_W'(TITLE_CHARS)) begin
                ram_we = 1'b1;
                ram_wdata = app_char;
                title_len_next = title_len + LEN_W'(1);
                if (app_char != 8'h20 && app_char != 8'h0D && app_char != 8'h0A) begin
                  kept_len_next = title_len_next;
                end
              end
              if (title_len_next >= LEN_W'(TITLE_CHARS)) chap_phase_next = C_DONE;
            end
          end
          if (frame_rem_next == 32'd0) begin
            is_rec = (frame_ident == ID_CHAP) && (chap_phase_next >= C_SUBHDR);
            if (is_rec) begin
              if (!presence_only && found < max_records) begin
                ev.rec = 1'b1;
                ev.idx = found[9:0];
              end
              found_next = found + 11'd1;
            end
            if (is_rec && presence_only) begin
              phase_next = PH_STOP;
            end else if (bf_fail(tag_pos_next, tag_len, found_next)) begin
              phase_next = PH_STOP;
            end else begin
              phase_next = PH_FHDR;
              hdr_count_next = '0;
              frame_ident_next = '0;
              frame_rem_next = '0;
            end
          end
        end
        default: ;
      endcase
      ev.done  = last_byte;
      ev.start = ev.rec ? start_time_next : 32'd0;
      ev.bank  = wbank;
      ev.count = last_byte ? found_next : 11'd0;
    end
  end

  assign ev_valid = accept && (ev.rec || last_byte);
  assign ev_kept  = kept_len_next;

  // end of file puts the whole parse back to its reset state
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase       <= PH_HDR;
      tag_pos     <= '0;
      tag_len     <= '0;
      hdr_bytes   <= '0;
      v4          <= 1'b0;
      ext_flag    <= 1'b0;
      frame_ident <= '0;
      frame_rem   <= '0;
      hdr_count   <= '0;
      chap_phase  <= C_ID;
      chap_off    <= '0;
      start_time  <= '0;
      sub_ident   <= '0;
      sub_rem     <= '0;
      little      <= 1'b0;
      pair_first  <= '0;
      title_len   <= '0;
      kept_len    <= '0;
      found       <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      tag_pos     <= tag_pos_next;
      tag_len     <= tag_len_next;
      hdr_bytes   <= hdr_bytes_next;
      v4          <= v4_next;
      ext_flag    <= ext_flag_next;
      frame_ident <= frame_ident_next;
      frame_rem   <= frame_rem_next;
      hdr_count   <= hdr_count_next;
      chap_phase  <= chap_phase_next;
      chap_off    <= chap_off_next;
      start_time  <= start_time_next;
      sub_ident   <= sub_ident_next;
      sub_rem     <= sub_rem_next;
      little      <= little_next;
      pair_first  <= pair_first_next;
      title_len   <= title_len_next;
      kept_len    <= kept_len_next;
      found       <= found_next;
    end
  end

  // title bank swaps on every record event that the parser emits
  always_ff @(posedge clk) begin
    if (rst) begin
      wbank <= 1'b0;
    end else if (accept && ev.rec) begin
      wbank <= ~wbank;
    end
  end

endmodule
